// File: rtl/core/bmp565_pkg.sv
// Shared constants, result word type and colour packing for the BMP to RGB565 decoder
package bmp565_pkg;

    localparam int unsigned HDR_BYTES     = 54;
    localparam int unsigned PAL_DEPTH     = 256;
    localparam int unsigned DEF_PANEL_W   = 135;
    localparam int unsigned DEF_PANEL_H   = 240;
    localparam logic [15:0] BMP_MAGIC     = 16'h4D42;

    // result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_OK     = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SHORT    = 3'd1;
    localparam logic [2:0] ERR_SIG      = 3'd2;
    localparam logic [2:0] ERR_COMPRESS = 3'd3;
    localparam logic [2:0] ERR_DEPTH    = 3'd4;
    localparam logic [2:0] ERR_SIZE     = 3'd5;
    localparam logic [2:0] ERR_LAYOUT   = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [15:0] colour;
        logic [2:0]  error_code;
        logic        final_res;
    } t_res;

    function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        to565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

// File: rtl/core/bmp_stream_to_rgb565_pixels_top.sv
// BMP byte stream to RGB565 panel pixels: header check, palette capture, pixel placement
// Each byte's results are registered in stage one and then written into the output queue.
// Throughput: one file byte per cycle while the result queue has room; one registered palette read per byte.
// Up to two results per byte leave through an eight-entry result queue, one per cycle while i_out_ready is high.
// Reset: synchronous, active low; clears the file position, latch, counters and queue.
// Header fields and palette contents are held without reset and rewritten by each file.
module bmp_stream_to_rgb565_pixels_top
    import bmp565_pkg::*;
#(
    parameter int unsigned PANEL_WIDTH  = DEF_PANEL_W,
    parameter int unsigned PANEL_HEIGHT = DEF_PANEL_H
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_pos_x,
    output logic [7:0]  o_pos_y,
    output logic [15:0] o_colour,
    output logic [2:0]  o_error_code,
    output logic        o_final_res
);

    localparam int unsigned WW = $clog2(PANEL_WIDTH + 1);
    localparam int unsigned HW = $clog2(PANEL_HEIGHT + 1);
    localparam int unsigned QD = 8;
    localparam int unsigned QA = $clog2(QD);

    // header fields, captured by byte position
    logic [15:0] r_sig, r_bpp;
    logic [31:0] r_data_off, r_hsize, r_w, r_h, r_comp, r_ncol;

    // per-file control state
    logic [31:0] r_pos;
    logic [2:0]  r_reject;
    logic        r_pal8, r_top;
    logic [32:0] r_pal_start;
    logic [34:0] r_pal_end;
    logic [15:0] r_img_h;
    logic [WW-1:0] r_draw_w, r_off_x;
    logic [HW-1:0] r_draw_h, r_off_y;
    logic [17:0] r_row_size, r_pix_bytes, r_rbc;
    logic [15:0] r_frow, r_pix_col, r_acc;
    logic [8:0]  r_ccount;
    logic [1:0]  r_phase;

    logic [31:0] n_pos;
    logic [2:0]  n_reject;
    logic        n_pal8, n_top;
    logic [32:0] n_pal_start;
    logic [34:0] n_pal_end;
    logic [15:0] n_img_h;
    logic [WW-1:0] n_draw_w, n_off_x;
    logic [HW-1:0] n_draw_h, n_off_y;
    logic [17:0] n_row_size, n_pix_bytes, n_rbc;
    logic [15:0] n_frow, n_pix_col, n_acc;
    logic [8:0]  n_ccount;
    logic [1:0]  n_phase;

    // palette, one memory per component
    logic [7:0]  r_pal_b [PAL_DEPTH];
    logic [7:0]  r_pal_g [PAL_DEPTH];
    logic [7:0]  r_pal_r [PAL_DEPTH];
    logic [7:0]  r_rd_b, r_rd_g, r_rd_r;
    logic        pal_we;
    logic [1:0]  pal_comp;
    logic [7:0]  pal_addr;

    // stage one result register
    logic        r_s1_pix_v, r_s1_fin_v, r_s1_use_pal;
    t_res        r_s1_pix, r_s1_fin;
    logic        n_s1_pix_v, n_s1_fin_v, n_s1_use_pal;
    t_res        n_s1_pix, n_s1_fin;

    // result queue
    t_res        r_q [QD];
    logic [QA-1:0] r_wr, r_rd;
    logic [QA:0] r_cnt;

    logic        accept, pop;
    logic [1:0]  s1_n;

    // header decode, used on the last header byte
    logic [31:0] d_habs, d_ncnt;
    logic        d_pal8, d_top;
    logic [2:0]  d_err;
    logic [32:0] d_pal_start;
    logic [34:0] d_pal_end;
    logic [20:0] d_bits;
    logic [21:0] d_rs_sum;
    logic [8:0]  d_ccount;

    // pixel step helpers
    logic        in_data, in_pal, shown, eof_pixel_fin;
    logic [15:0] oy;
    logic [34:0] pal_off;
    logic [16:0] x_sum, y_sum;
    logic [17:0] rbc_inc;
    logic        eff_pal8;
    logic [2:0]  eff_reject, fin_code;
    logic [34:0] eff_pal_end;
    logic [5:0]  p_lo, lane_base;

    assign s1_n       = {1'b0, r_s1_pix_v} + {1'b0, r_s1_fin_v};
    assign o_in_ready = ({1'b0, r_cnt} + {{QA{1'b0}}, s1_n}) <= (QA + 2)'(QD - 2);
    assign accept     = i_in_valid && o_in_ready;
    assign pop        = o_out_valid && i_out_ready;

    // header decode
    always_comb begin
        d_top       = r_h[31];
        d_habs      = d_top ? (32'd0 - r_h) : r_h;
        d_pal8      = (r_bpp == 16'd8);
        d_ncnt      = (r_ncol == 32'd0) ? 32'd256 : r_ncol;
        d_pal_start = 33'd14 + {1'b0, r_hsize};
        d_pal_end   = {2'b00, d_pal_start} + {1'b0, d_ncnt, 2'b00};
        d_ccount    = (r_ncol == 32'd0 || r_ncol > 32'd256) ? 9'd256 : r_ncol[8:0];
        d_bits      = d_pal8 ? {2'b00, r_w[15:0], 3'b000}
                             : ({1'b0, r_w[15:0], 4'b0000} + {2'b00, r_w[15:0], 3'b000});
        d_rs_sum    = {1'b0, d_bits} + 22'd31;
        if (r_sig != BMP_MAGIC) begin
            d_err = ERR_SIG;
        end else if (r_comp != 32'd0) begin
            d_err = ERR_COMPRESS;
        end else if (r_bpp != 16'd24 && r_bpp != 16'd8) begin
            d_err = ERR_DEPTH;
        end else if (r_w == 32'd0 || r_w > 32'd65535 || d_habs == 32'd0
                     || d_habs > 32'd65535) begin
            d_err = ERR_SIZE;
        end else if (d_pal8 && (d_pal_start < 33'(HDR_BYTES)
                     || {3'b000, r_data_off} < d_pal_end)) begin
            d_err = ERR_LAYOUT;
        end else if (!d_pal8 && r_data_off < 32'(HDR_BYTES)) begin
            d_err = ERR_LAYOUT;
        end else begin
            d_err = ERR_NONE;
        end
    end

    // per-byte step
    always_comb begin
        n_pos       = r_pos;
        n_reject    = r_reject;
        n_pal8      = r_pal8;
        n_top       = r_top;
        n_pal_start = r_pal_start;
        n_pal_end   = r_pal_end;
        n_img_h     = r_img_h;
        n_draw_w    = r_draw_w;
        n_draw_h    = r_draw_h;
        n_off_x     = r_off_x;
        n_off_y     = r_off_y;
        n_row_size  = r_row_size;
        n_pix_bytes = r_pix_bytes;
        n_rbc       = r_rbc;
        n_frow      = r_frow;
        n_pix_col   = r_pix_col;
        n_acc       = r_acc;
        n_ccount    = r_ccount;
        n_phase     = r_phase;
        n_s1_pix_v   = 1'b0;
        n_s1_fin_v   = 1'b0;
        n_s1_use_pal = 1'b0;
        n_s1_pix     = '0;
        n_s1_fin     = '0;
        pal_we       = 1'b0;
        eof_pixel_fin = !i_end_of_file;

        in_data = (r_pos >= 32'(HDR_BYTES)) && (r_reject == ERR_NONE);
        pal_off = {3'b000, r_pos} - {2'b00, r_pal_start};
        in_pal  = in_data && r_pal8 && ({1'b0, r_pos} >= r_pal_start)
                  && ({3'b000, r_pos} < r_pal_end);
        pal_comp = pal_off[1:0];
        pal_addr = pal_off[9:2];
        shown   = r_top ? (r_frow < 16'(r_draw_h)) : (r_frow >= (r_img_h - 16'(r_draw_h)));
        oy      = r_top ? r_frow : (r_img_h - 16'd1 - r_frow);
        x_sum   = 17'(r_off_x) + {1'b0, r_pix_col};
        y_sum   = 17'(r_off_y) + {1'b0, oy};
        rbc_inc = r_rbc + 18'd1;

        if (accept) begin
            if (r_pos != 32'hFFFF_FFFF) begin
                n_pos = r_pos + 32'd1;
            end

            // header decode on the last header byte
            if (r_pos == 32'(HDR_BYTES - 1)) begin
                n_reject = d_err;
                if (r_sig == BMP_MAGIC && r_comp == 32'd0
                    && (r_bpp == 16'd24 || r_bpp == 16'd8)) begin
                    n_pal8 = d_pal8;
                    n_top  = d_top;
                end
                n_img_h     = d_habs[15:0];
                n_pal_start = d_pal_start;
                n_pal_end   = d_pal8 ? d_pal_end : {2'b00, d_pal_start};
                n_ccount    = d_pal8 ? d_ccount : 9'd0;
                n_row_size  = 18'({d_rs_sum[21:5], 2'b00});
                n_pix_bytes = d_pal8 ? {2'b00, r_w[15:0]}
                                     : ({2'b00, r_w[15:0]} + {1'b0, r_w[15:0], 1'b0});
                n_draw_w    = ({16'd0, r_w[15:0]} < 32'(PANEL_WIDTH)) ? WW'(r_w[15:0])
                                                                      : WW'(PANEL_WIDTH);
                n_draw_h    = ({16'd0, d_habs[15:0]} < 32'(PANEL_HEIGHT)) ? HW'(d_habs[15:0])
                                                                          : HW'(PANEL_HEIGHT);
                n_off_x     = (WW'(PANEL_WIDTH) - n_draw_w) >> 1;
                n_off_y     = (HW'(PANEL_HEIGHT) - n_draw_h) >> 1;
            end

            // palette capture, unused fourth byte skipped
            if (in_pal && pal_off[34:10] == '0 && pal_comp != 2'd3) begin
                pal_we = 1'b1;
            end

            // pixel data
            if (in_data && r_pos >= r_data_off && r_frow < r_img_h) begin
                if (r_rbc < r_pix_bytes) begin
                    if (r_pal8) begin
                        n_s1_use_pal = ({1'b0, i_file_byte} < r_ccount);
                        n_s1_pix_v   = shown && ({{(16 - WW){1'b0}}, r_draw_w} > r_pix_col);
                        n_pix_col    = r_pix_col + 16'd1;
                    end else if (r_phase == 2'd0) begin
                        n_acc   = {8'd0, i_file_byte};
                        n_phase = 2'd1;
                    end else if (r_phase == 2'd1) begin
                        n_acc   = {i_file_byte, r_acc[7:0]};
                        n_phase = 2'd2;
                    end else begin
                        n_s1_pix.colour = to565(i_file_byte, r_acc[15:8], r_acc[7:0]);
                        n_phase   = 2'd0;
                        n_s1_pix_v = shown && ({{(16 - WW){1'b0}}, r_draw_w} > r_pix_col);
                        n_pix_col  = r_pix_col + 16'd1;
                    end
                end
                n_s1_pix.kind       = KIND_PIXEL;
                n_s1_pix.pos_x      = x_sum[7:0];
                n_s1_pix.pos_y      = y_sum[7:0];
                n_s1_pix.error_code = ERR_NONE;
                n_s1_pix.final_res  = eof_pixel_fin;
                n_rbc = rbc_inc;
                if (rbc_inc >= r_row_size) begin
                    n_rbc     = '0;
                    n_frow    = r_frow + 16'd1;
                    n_pix_col = '0;
                    n_phase   = 2'd0;
                end
            end

            // end of file: final result and return to the start of a new file
            if (i_end_of_file) begin
                n_s1_fin_v = 1'b1;
                n_s1_fin.final_res = 1'b1;
                n_s1_fin.error_code = fin_code;
                n_s1_fin.kind = (fin_code != ERR_NONE) ? KIND_REJECT : KIND_OK;
                n_pos     = '0;
                n_reject  = ERR_NONE;
                n_pal8    = 1'b0;
                n_top     = 1'b0;
                n_rbc     = '0;
                n_frow    = '0;
                n_pix_col = '0;
                n_acc     = '0;
                n_ccount  = '0;
                n_phase   = 2'd0;
            end
        end
    end

    // final code sees a decode made on this same byte
    always_comb begin
        eff_reject  = (r_pos == 32'(HDR_BYTES - 1)) ? d_err : r_reject;
        eff_pal8    = (r_pos == 32'(HDR_BYTES - 1)) ? d_pal8 : r_pal8;
        eff_pal_end = (r_pos == 32'(HDR_BYTES - 1)) ? d_pal_end : r_pal_end;
        if (r_pos < 32'(HDR_BYTES - 1)) begin
            fin_code = ERR_SHORT;
        end else if (eff_reject != ERR_NONE) begin
            fin_code = eff_reject;
        end else if (eff_pal8 && eff_pal_end > ({3'b000, r_pos} + 35'd1)) begin
            fin_code = ERR_SHORT;
        end else begin
            fin_code = ERR_NONE;
        end
    end

    // header byte capture
    assign p_lo = r_pos[5:0];
    always_comb begin
        if (p_lo >= 6'd46) begin
            lane_base = p_lo - 6'd46;
        end else if (p_lo >= 6'd30) begin
            lane_base = p_lo - 6'd30;
        end else if (p_lo >= 6'd28) begin
            lane_base = p_lo - 6'd28;
        end else if (p_lo >= 6'd22) begin
            lane_base = p_lo - 6'd22;
        end else if (p_lo >= 6'd18) begin
            lane_base = p_lo - 6'd18;
        end else if (p_lo >= 6'd14) begin
            lane_base = p_lo - 6'd14;
        end else if (p_lo >= 6'd10) begin
            lane_base = p_lo - 6'd10;
        end else begin
            lane_base = p_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_pos < 32'(HDR_BYTES)) begin
            if (p_lo < 6'd2) begin
                r_sig[{lane_base[0], 3'b000} +: 8] <= i_file_byte;
            end else if (p_lo >= 6'd10 && p_lo < 6'd14) begin
                r_data_off[{lane_base[1:0], 3'b000} +: 8] <= i_file_byte;
            end else if (p_lo >= 6'd14 && p_lo < 6'd18) begin
                r_hsize[{lane_base[1:0], 3'b000} +: 8] <= i_file_byte;
            end else if (p_lo >= 6'd18 && p_lo < 6'd22) begin
                r_w[{lane_base[1:0], 3'b000} +: 8] <= i_file_byte;
            end else if (p_lo >= 6'd22 && p_lo < 6'd26) begin
                r_h[{lane_base[1:0], 3'b000} +: 8] <= i_file_byte;
            end else if (p_lo >= 6'd28 && p_lo < 6'd30) begin
                r_bpp[{lane_base[0], 3'b000} +: 8] <= i_file_byte;
            end else if (p_lo >= 6'd30 && p_lo < 6'd34) begin
                r_comp[{lane_base[1:0], 3'b000} +: 8] <= i_file_byte;
            end else if (p_lo >= 6'd46 && p_lo < 6'd50) begin
                r_ncol[{lane_base[1:0], 3'b000} +: 8] <= i_file_byte;
            end
        end
    end

    // palette memories: byte-lane write, registered read by pixel index
    always_ff @(posedge i_clk) begin
        if (pal_we && pal_comp == 2'd0) begin
            r_pal_b[pal_addr] <= i_file_byte;
        end
        if (pal_we && pal_comp == 2'd1) begin
            r_pal_g[pal_addr] <= i_file_byte;
        end
        if (pal_we && pal_comp == 2'd2) begin
            r_pal_r[pal_addr] <= i_file_byte;
        end
        r_rd_b <= r_pal_b[i_file_byte];
        r_rd_g <= r_pal_g[i_file_byte];
        r_rd_r <= r_pal_r[i_file_byte];
    end

    // file state and stage one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_reject   <= ERR_NONE;
            r_pal8     <= 1'b0;
            r_top      <= 1'b0;
            r_rbc      <= '0;
            r_frow     <= '0;
            r_pix_col  <= '0;
            r_acc      <= '0;
            r_ccount   <= '0;
            r_phase    <= 2'd0;
            r_s1_pix_v <= 1'b0;
            r_s1_fin_v <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_reject   <= n_reject;
            r_pal8     <= n_pal8;
            r_top      <= n_top;
            r_rbc      <= n_rbc;
            r_frow     <= n_frow;
            r_pix_col  <= n_pix_col;
            r_acc      <= n_acc;
            r_ccount   <= n_ccount;
            r_phase    <= n_phase;
            r_s1_pix_v <= n_s1_pix_v;
            r_s1_fin_v <= n_s1_fin_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pal_start  <= n_pal_start;
        r_pal_end    <= n_pal_end;
        r_img_h      <= n_img_h;
        r_draw_w     <= n_draw_w;
        r_draw_h     <= n_draw_h;
        r_off_x      <= n_off_x;
        r_off_y      <= n_off_y;
        r_row_size   <= n_row_size;
        r_pix_bytes  <= n_pix_bytes;
        r_s1_use_pal <= n_s1_use_pal;
        r_s1_pix     <= n_s1_pix;
        r_s1_fin     <= n_s1_fin;
    end

    // stage two: palette colour joins, results pushed to the queue
    t_res pix_out;
    always_comb begin
        pix_out = r_s1_pix;
        if (r_pal8 || r_s1_use_pal) begin
            pix_out.colour = r_s1_use_pal ? to565(r_rd_r, r_rd_g, r_rd_b) : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_pix_v) begin
            r_q[r_wr] <= pix_out;
        end
        if (r_s1_fin_v) begin
            r_q[r_s1_pix_v ? (r_wr + QA'(1)) : r_wr] <= r_s1_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QA'(s1_n);
            r_rd  <= r_rd + QA'(pop);
            r_cnt <= r_cnt + (QA + 1)'(s1_n) - (QA + 1)'(pop);
        end
    end

    assign o_out_valid  = (r_cnt != '0);
    assign o_kind       = r_q[r_rd].kind;
    assign o_pos_x      = r_q[r_rd].pos_x;
    assign o_pos_y      = r_q[r_rd].pos_y;
    assign o_colour     = r_q[r_rd].colour;
    assign o_error_code = r_q[r_rd].error_code;
    assign o_final_res  = r_q[r_rd].final_res;

endmodule
